// ===== rtl/core/streaming_top_k_select_assert.svh =====
// Assertion macros for the streaming top-K selection block.
// Each macro expects a signal named clock in the using scope; TKS_ASSERT also expects reset.
`ifndef STREAMING_TOP_K_SELECT_ASSERT_SVH
`define STREAMING_TOP_K_SELECT_ASSERT_SVH

// Checks a property on every rising clock edge outside of reset.
`define TKS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define TKS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/core/tks_pkg.sv =====
// Shared constants and types for the streaming top-K selection block.
// No dependencies; every module of the block imports this package.
package tks_pkg;

   localparam int SCORE_W         = 32;
   localparam int IDX_W           = 16;
   localparam int RANK_W          = 3;
   localparam int CFG_W           = 3;
   localparam int IN_TDATA_W      = 32;
   localparam int OUT_TDATA_W     = 56;
   localparam int DEF_TOP_K       = 5;
   localparam int DEF_MAX_CLASSES = 65536;
   localparam int Q_DEPTH         = 2;

   localparam logic [CFG_W-1:0] WANTED_RESET = CFG_W'(5);

   // Status of the frame queue seen by its producer and consumer.
   typedef struct packed {
      logic full;
      logic nonempty;
   } q_status_type;

endpackage

// ===== rtl/core/streaming_top_k_select.sv =====
// Streaming top-K selection: top level tying front end, frame queue and back end.
// Depends on tks_pkg, tks_front, tks_queue, tks_back and the assertion header.
//
// The block takes one classifier score per beat on the req_ channel and numbers
// each by its stream position, starting at 0 and wrapping after MAX_CLASSES - 1.
// It keeps the TOP_K largest scores with their positions in descending order; a
// score enters only when it is strictly greater than a kept score, and slots
// start at score 0, position 0, so only positive scores can enter and earlier
// positions win ties. The beat with tlast set closes the stream: its score is
// ranked first, then the frame of ranked slots moves to a two-frame queue and
// the slots and position counter clear for the next stream. The back end sends
// results_wanted ranked results (0 is taken as 1, values above TOP_K as TOP_K),
// best first, one per beat on the rsp_ channel, with tlast on the final one.
// Scores are taken at one per clock cycle while req_tready is high; the compare
// and shift into the TOP_K slot registers is combinational and sets that rate.
// A closed frame goes via the queue registers to the back end's output register,
// which sends results at one per cycle while rsp_tready is high. The input stalls
// only while two closed frames wait in the queue. The user must write results_wanted
// via csr_ only while the block is idle, unenforced; it is taken when a stream closes.
module streaming_top_k_select #(
   parameter int TOP_K       = tks_pkg::DEF_TOP_K,
   parameter int MAX_CLASSES = tks_pkg::DEF_MAX_CLASSES
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [31:0] score
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tks_pkg::IN_TDATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: [2:0] rank, [18:3] class_index, [50:19] best_score, [55:51] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tks_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // Configuration: results_wanted.
   input  logic                            csr_wr_en,
   input  logic [tks_pkg::CFG_W-1:0]       csr_wr_data
);
   import tks_pkg::*;

   `include "streaming_top_k_select_assert.svh"

   localparam int CNT_W = $clog2(TOP_K + 1);

   q_status_type              q_status;
   logic                      req_fire;
   logic                      q_push, q_pop;
   logic signed [SCORE_W-1:0] push_score [TOP_K];
   logic [IDX_W-1:0]          push_pos   [TOP_K];
   logic [CNT_W-1:0]          push_cnt;
   logic signed [SCORE_W-1:0] head_score [TOP_K];
   logic [IDX_W-1:0]          head_pos   [TOP_K];
   logic [CNT_W-1:0]          head_cnt;
   logic [RANK_W-1:0]         out_rank;
   logic [IDX_W-1:0]          out_pos;
   logic [SCORE_W-1:0]        out_score;
   logic                      rsp_fire;

   // A beat is refused only while the queue has no room for a closing frame.
   assign req_tready = ~q_status.full;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   tks_front #(
      .TOP_K       (TOP_K),
      .MAX_CLASSES (MAX_CLASSES),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (req_fire),
      .in_score    (req_tdata[SCORE_W-1:0]),
      .in_final    (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (q_push),
      .push_score  (push_score),
      .push_pos    (push_pos),
      .push_cnt    (push_cnt)
   );

   tks_queue #(
      .TOP_K (TOP_K),
      .CNT_W (CNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_score (push_score),
      .push_pos   (push_pos),
      .push_cnt   (push_cnt),
      .pop        (q_pop),
      .status     (q_status),
      .head_score (head_score),
      .head_pos   (head_pos),
      .head_cnt   (head_cnt)
   );

   tks_back #(
      .TOP_K (TOP_K),
      .CNT_W (CNT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (q_status),
      .head_score (head_score),
      .head_pos   (head_pos),
      .head_cnt   (head_cnt),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rank   (out_rank),
      .out_pos    (out_pos),
      .out_score  (out_score),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {(OUT_TDATA_W - RANK_W - IDX_W - SCORE_W)'(0),
                       out_score, out_pos, out_rank};

   // A closing frame is never pushed into a full queue.
   `TKS_ASSERT(a_no_push_when_full, q_push |-> !q_status.full, "frame pushed into full queue")

   // Within a frame, results follow without a gap and with rising rank.
   `TKS_ASSERT(a_frame_continues, (rsp_fire && !rsp_tlast) |=> (rsp_tvalid && (out_rank == RANK_W'($past(out_rank) + RANK_W'(1)))), "ranked frame broken or rank skipped")

   // A new frame always starts at the best rank.
   `TKS_ASSERT(a_frame_starts_at_best, (rsp_fire && rsp_tlast) |=> (!rsp_tvalid || (out_rank == '0)), "frame does not start at rank zero")

   // The back end only takes a frame that the queue holds.
   `TKS_ASSERT(a_pop_needs_frame, q_pop |-> q_status.nonempty, "frame taken from empty queue")

endmodule

// ===== rtl/core/tks_front.sv =====
// Front end of the top-K block: accepts scores, keeps the ranked slots
// and hands a finished frame to the queue. Depends on tks_pkg.
module tks_front #(
   parameter int TOP_K       = 5,
   parameter int MAX_CLASSES = 65536,
   parameter int CNT_W       = $clog2(TOP_K + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_fire,
   input  logic [tks_pkg::SCORE_W-1:0]  in_score,
   input  logic                         in_final,
   input  logic                         csr_wr_en,
   input  logic [tks_pkg::CFG_W-1:0]    csr_wr_data,
   output logic                         push,
   output logic signed [tks_pkg::SCORE_W-1:0] push_score [TOP_K],
   output logic [tks_pkg::IDX_W-1:0]    push_pos [TOP_K],
   output logic [CNT_W-1:0]             push_cnt
);
   import tks_pkg::*;

   localparam int POS_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;

   logic signed [SCORE_W-1:0] kept_score_ff [TOP_K];
   logic signed [SCORE_W-1:0] kept_score_in [TOP_K];
   logic [IDX_W-1:0]          kept_pos_ff   [TOP_K];
   logic [IDX_W-1:0]          kept_pos_in   [TOP_K];
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [CFG_W-1:0]          wanted_ff, wanted_in;
   logic [TOP_K-1:0]          gt;
   logic signed [SCORE_W-1:0] s;
   logic [IDX_W-1:0]          cur_pos;

   assign s       = $signed(in_score);
   assign cur_pos = IDX_W'(pos_ff);

   // The slots stay in descending order, so the compare results form a
   // thermometer code: the new score lands at the first slot it beats.
   always_comb begin
      for (int j = 0; j < TOP_K; j++) begin
         gt[j] = s > kept_score_ff[j];
      end
      push_score[0] = gt[0] ? s : kept_score_ff[0];
      push_pos[0]   = gt[0] ? cur_pos : kept_pos_ff[0];
      for (int j = 1; j < TOP_K; j++) begin
         if (gt[j - 1]) begin
            push_score[j] = kept_score_ff[j - 1];
            push_pos[j]   = kept_pos_ff[j - 1];
         end else if (gt[j]) begin
            push_score[j] = s;
            push_pos[j]   = cur_pos;
         end else begin
            push_score[j] = kept_score_ff[j];
            push_pos[j]   = kept_pos_ff[j];
         end
      end
   end

   always_comb begin
      if (wanted_ff == '0) begin
         push_cnt = CNT_W'(1);
      end else if (int'(wanted_ff) > TOP_K) begin
         push_cnt = CNT_W'(TOP_K);
      end else begin
         push_cnt = CNT_W'(wanted_ff);
      end
   end

   assign push = in_fire & in_final;

   always_comb begin
      kept_score_in = kept_score_ff;
      kept_pos_in   = kept_pos_ff;
      pos_in        = pos_ff;
      wanted_in     = csr_wr_en ? csr_wr_data : wanted_ff;
      if (in_fire) begin
         if (in_final) begin
            for (int j = 0; j < TOP_K; j++) begin
               kept_score_in[j] = '0;
               kept_pos_in[j]   = '0;
            end
            pos_in = '0;
         end else begin
            kept_score_in = push_score;
            kept_pos_in   = push_pos;
            pos_in = (pos_ff == POS_W'(MAX_CLASSES - 1)) ? '0 : pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TOP_K; j++) begin
            kept_score_ff[j] <= '0;
            kept_pos_ff[j]   <= '0;
         end
         pos_ff    <= '0;
         wanted_ff <= WANTED_RESET;
      end else begin
         kept_score_ff <= kept_score_in;
         kept_pos_ff   <= kept_pos_in;
         pos_ff        <= pos_in;
         wanted_ff     <= wanted_in;
      end
   end

endmodule

// ===== rtl/core/tks_queue.sv =====
// Frame queue between the front and back ends of the top-K block.
// Holds finished ranked frames with their result count. Depends on tks_pkg.
module tks_queue #(
   parameter int TOP_K = 5,
   parameter int CNT_W = $clog2(TOP_K + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic signed [tks_pkg::SCORE_W-1:0] push_score [TOP_K],
   input  logic [tks_pkg::IDX_W-1:0]    push_pos [TOP_K],
   input  logic [CNT_W-1:0]             push_cnt,
   input  logic                         pop,
   output tks_pkg::q_status_type        status,
   output logic signed [tks_pkg::SCORE_W-1:0] head_score [TOP_K],
   output logic [tks_pkg::IDX_W-1:0]    head_pos [TOP_K],
   output logic [CNT_W-1:0]             head_cnt
);
   import tks_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int OCC_W = $clog2(Q_DEPTH + 1);

   logic signed [SCORE_W-1:0] ent_score_ff [Q_DEPTH][TOP_K];
   logic [IDX_W-1:0]          ent_pos_ff   [Q_DEPTH][TOP_K];
   logic [CNT_W-1:0]          ent_cnt_ff   [Q_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]          occ_ff, occ_in;

   assign status.full     = (occ_ff == OCC_W'(Q_DEPTH));
   assign status.nonempty = (occ_ff != '0);

   assign head_score = ent_score_ff[rd_ptr_ff];
   assign head_pos   = ent_pos_ff[rd_ptr_ff];
   assign head_cnt   = ent_cnt_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   occ_in = occ_ff + OCC_W'(1);
         2'b01:   occ_in = occ_ff - OCC_W'(1);
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_score_ff[wr_ptr_ff] <= push_score;
         ent_pos_ff[wr_ptr_ff]   <= push_pos;
         ent_cnt_ff[wr_ptr_ff]   <= push_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

endmodule

// ===== rtl/core/tks_back.sv =====
// Back end of the top-K block: takes a frame from the queue and sends its
// ranked results out one beat at a time, best first. Depends on tks_pkg.
module tks_back #(
   parameter int TOP_K = 5,
   parameter int CNT_W = $clog2(TOP_K + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tks_pkg::q_status_type        status,
   input  logic signed [tks_pkg::SCORE_W-1:0] head_score [TOP_K],
   input  logic [tks_pkg::IDX_W-1:0]    head_pos [TOP_K],
   input  logic [CNT_W-1:0]             head_cnt,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [tks_pkg::RANK_W-1:0]   out_rank,
   output logic [tks_pkg::IDX_W-1:0]    out_pos,
   output logic [tks_pkg::SCORE_W-1:0]  out_score,
   output logic                         out_last
);
   import tks_pkg::*;

   logic                      active_ff, active_in;
   logic signed [SCORE_W-1:0] score_ff [TOP_K];
   logic signed [SCORE_W-1:0] score_in [TOP_K];
   logic [IDX_W-1:0]          pos_ff   [TOP_K];
   logic [IDX_W-1:0]          pos_in   [TOP_K];
   logic [CNT_W-1:0]          left_ff, left_in;
   logic [CNT_W-1:0]          rank_ff, rank_in;
   logic                      fire;

   assign out_valid = active_ff;
   assign out_last  = (left_ff == CNT_W'(1));
   assign out_rank  = RANK_W'(rank_ff);
   assign out_pos   = pos_ff[0];
   assign out_score = score_ff[0];

   assign fire = active_ff & out_ready;
   assign pop  = status.nonempty & (~active_ff | (fire & out_last));

   always_comb begin
      active_in = active_ff;
      score_in  = score_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      rank_in   = rank_ff;
      if (pop) begin
         active_in = 1'b1;
         score_in  = head_score;
         pos_in    = head_pos;
         left_in   = head_cnt;
         rank_in   = '0;
      end else if (fire) begin
         if (out_last) begin
            active_in = 1'b0;
         end else begin
            for (int j = 0; j < TOP_K - 1; j++) begin
               score_in[j] = score_ff[j + 1];
               pos_in[j]   = pos_ff[j + 1];
            end
            score_in[TOP_K - 1] = '0;
            pos_in[TOP_K - 1]   = '0;
            left_in = left_ff - CNT_W'(1);
            rank_in = rank_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      pos_ff   <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         left_ff   <= '0;
         rank_ff   <= '0;
      end else begin
         active_ff <= active_in;
         left_ff   <= left_in;
         rank_ff   <= rank_in;
      end
   end

endmodule

// ===== verif/tb_streaming_top_k_select.sv =====
// Self-checking testbench for the streaming top-K selection block.
// Depends on tks_pkg and the streaming_top_k_select RTL. It holds its own ranking
// predictor in a scoreboard class and drives the req_, rsp_ and csr_ ports.
package topk_check_pkg;
   import tks_pkg::*;

   localparam int SLOTS = tks_pkg::DEF_TOP_K;

   typedef struct packed {
      logic [RANK_W-1:0]         rank;
      logic [IDX_W-1:0]          class_index;
      logic signed [SCORE_W-1:0] best_score;
      logic                      last_result;
   } ranked_entry_type;

   // Keeps the best scores of the open stream and the queue of ranked beats
   // that the block still owes on its result channel.
   class topk_scoreboard;
      logic signed [SCORE_W-1:0] slot_score[SLOTS];
      logic [IDX_W-1:0]          slot_pos[SLOTS];
      logic [IDX_W-1:0]          next_pos;
      logic [CFG_W-1:0]          wanted;
      ranked_entry_type          ranked_q[$];
      int                        mismatches;

      function new();
         clear_slots();
         wanted     = WANTED_RESET;
         mismatches = 0;
      endfunction

      function void clear_slots();
         for (int j = 0; j < SLOTS; j++) begin
            slot_score[j] = '0;
            slot_pos[j]   = '0;
         end
         next_pos = '0;
      endfunction

      function void set_wanted(logic [CFG_W-1:0] value);
         wanted = value;
      endfunction

      function int pending();
         return ranked_q.size();
      endfunction

      // Ranks one accepted score; a closing beat queues the ranked results.
      function void note_score(logic [SCORE_W-1:0] raw, logic closing);
         logic signed [SCORE_W-1:0] s;
         bit                        placed;
         int                        n;
         ranked_entry_type          e;
         s      = raw;
         placed = 1'b0;
         for (int j = 0; j < SLOTS; j++) begin
            if (!placed && s > slot_score[j]) begin
               for (int k = SLOTS - 1; k > j; k--) begin
                  slot_score[k] = slot_score[k-1];
                  slot_pos[k]   = slot_pos[k-1];
               end
               slot_score[j] = s;
               slot_pos[j]   = next_pos;
               placed        = 1'b1;
            end
         end
         next_pos = next_pos + IDX_W'(1);
         if (closing) begin
            n = int'(wanted);
            if (n < 1) n = 1;
            if (n > SLOTS) n = SLOTS;
            for (int k = 0; k < n; k++) begin
               e.rank        = RANK_W'(k);
               e.class_index = slot_pos[k];
               e.best_score  = slot_score[k];
               e.last_result = (k == n - 1);
               ranked_q.push_back(e);
            end
            clear_slots();
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [OUT_TDATA_W-1:0] data, logic tlast);
         ranked_entry_type e;
         if (ranked_q.size() == 0) begin
            $error("result beat with nothing pending: tdata 0x%014h tlast %0b", data, tlast);
            mismatches++;
            return;
         end
         e = ranked_q.pop_front();
         compare_field("rank",        32'(e.rank),        32'(data[2:0]));
         compare_field("class_index", 32'(e.class_index), 32'(data[18:3]));
         compare_field("best_score",  e.best_score,       data[50:19]);
         compare_field("last_result", 32'(e.last_result), 32'(tlast));
         compare_field("tdata_pad",   32'd0,              32'(data[55:51]));
      endfunction
   endclass
endpackage

module tb_streaming_top_k_select;
   timeunit 1ns;
   timeprecision 1ps;

   import tks_pkg::*;
   import topk_check_pkg::*;

   // Cycles allowed after the last pending beat before the next register
   // write or the end of the run.
   localparam int SETTLE_CYCLES = 8;
   // Length of the long result-side hold-off that fills the frame queue.
   localparam int HOLD_CYCLES   = 80;
   // Generous bound: even with every beat closing a five-result stream under
   // the longest stalls, a correct run stays well below it.
   localparam int CYCLE_LIMIT   = 50000;
   localparam int PHASE_ITEMS   = 9;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   logic [CFG_W-1:0]       csr_wr_data = '0;

   // Control shared between the stimulus and the result-side process.
   bit src_idle_en   = 1'b1;
   bit sink_stall_en = 1'b1;
   bit hold_request  = 1'b0;
   bit hold_active   = 1'b0;

   topk_scoreboard sb;

   streaming_top_k_select dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Both channels are watched at the clock edge. The values read right after
   // the edge are the ones the block saw, since every driver uses nonblocking
   // assignments and the block's state changes only in the update region.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_score(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // Result side. Normally ready, with random stall bursts.
   // On request it holds off for HOLD_CYCLES, counted here, so that closed
   // frames pile up in the queue and the block has to stall its input.
   initial begin : result_sink
      int n;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
            rsp_tready <= 1'b1;
         end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a correct run ends far below this cycle count.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offers one score beat and returns at the edge where it is accepted.
   // The valid stays high afterwards so back-to-back beats need no gap; an
   // optional idle burst lowers it first.
   task automatic send_beat(input logic [SCORE_W-1:0] score, input logic closing);
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= score;
      req_tlast  <= closing;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Score mix: wide random values, small values that tie often, the
   // extremes, and plenty of non-positive values that never enter a slot.
   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2, 3:    return {1'b0, 31'($urandom)};
         4, 5:    return SCORE_W'($urandom_range(1, 8));
         6:       return {1'b1, 31'($urandom)};
         7:       return '0;
         8:       return SCORE_W'($urandom_range(0, 0) - 1);
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic random_stream(input int len);
      for (int i = 0; i < len; i++) send_beat(pick_score(), i == len - 1);
   endtask

   // Stops offering beats until every pending result beat has arrived, then
   // lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_wanted(input logic [CFG_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      sb.set_wanted(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] phase_wanted[8];
      int count;
      int len;
      sb = new();
      phase_wanted = '{3'd1, 3'd0, 3'd6, 3'd3, 3'd2, 3'd4, 3'd7, 3'd5};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset setting of five results.
      // A one-beat stream with the largest score: four unfilled slots follow.
      send_beat(32'h7FFF_FFFF, 1'b1);
      // Extremes, a tie on equal scores, and more positive scores than slots
      // so the smallest ones drop out; the closing score enters mid-table.
      send_beat(32'h8000_0000, 1'b0);
      send_beat(32'hFFFF_FFFF, 1'b0);
      send_beat(32'h0000_0000, 1'b0);
      send_beat(32'h0000_0001, 1'b0);
      send_beat(32'h0000_0001, 1'b0);
      send_beat(32'h7FFF_FFFF, 1'b0);
      send_beat(32'h0000_0005, 1'b0);
      send_beat(32'h0000_0003, 1'b0);
      send_beat(32'h0000_0002, 1'b0);
      send_beat(32'h0000_0004, 1'b1);
      // Only non-positive scores: every slot comes out empty.
      send_beat(32'h0000_0000, 1'b0);
      send_beat(32'hFFFF_FFFB, 1'b1);
      // Rising scores, the closing beat carrying the best one.
      send_beat(32'h0001_0000, 1'b0);
      send_beat(32'h0002_0000, 1'b0);
      send_beat(32'h0003_0000, 1'b0);
      send_beat(32'h0004_0000, 1'b1);

      // Hold the result side off while short streams keep coming without
      // idling, so the frame queue fills and the input channel backs up.
      drain();
      hold_request = 1'b1;
      wait (hold_active);
      src_idle_en = 1'b0;
      for (int i = 0; i < 4; i++) random_stream(2);
      src_idle_en = 1'b1;
      drain();

      // Random streams, one register setting per phase; the last phase runs
      // with no idling on either side.
      for (int p = 0; p < 8; p++) begin
         write_wanted(p == 6 ? CFG_W'($urandom_range(0, 7)) : phase_wanted[p]);
         if (p == 7) begin
            src_idle_en   = 1'b0;
            sink_stall_en = 1'b0;
         end
         count = 0;
         while (count < PHASE_ITEMS) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            random_stream(len);
            count += len;
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
